// ----- rtl/bilinear_height_sampler_macros.svh -----
// Assertion macros shared by the height sampler RTL.
`ifndef BILINEAR_HEIGHT_SAMPLER_MACROS_SVH
`define BILINEAR_HEIGHT_SAMPLER_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define BHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every rising edge of clk outside reset.
`define BHS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bhs_pkg.sv -----
// Constants and types of the bilinear height sampler.
package bhs_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int HEIGHT_BITS = 24;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int SIDE_W     = 9;
  localparam int RADIUS_W   = 31;
  localparam int CPU_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int POS_W      = 32;
  localparam int SUM_W      = POS_W + 1;
  localparam int CIDX_W     = 16;
  localparam int HIN_W      = 24;
  localparam int HOUT_W     = 24;

  // Cell index as row*side+column before the store range check.
  localparam int IDX_W = (ADDR_W >= 2 * SIDE_W + 1) ? ADDR_W + 1 : 2 * SIDE_W + 1;

  localparam int FRAC_W      = 17;
  localparam int FRAC_SHIFT  = FRAC_W - 1;
  localparam int ROUND_HALF  = 1 << (FRAC_SHIFT - 1);
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_SHIFT;

  localparam int DIFF_W = HEIGHT_BITS + 1;
  localparam int FMUL_W = FRAC_W + 1;
  localparam int PM_W   = DIFF_W + FMUL_W;
  localparam int Q_W    = PM_W - FRAC_SHIFT;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIDE      = 2'd0,
    REG_LAND_RADIUS    = 2'd1,
    REG_CELLS_PER_UNIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SIDE_W-1:0] base;
    logic [FRAC_W-1:0] frac;
  } axis_t;

endpackage

// ----- rtl/bhs_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module bhs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- rtl/bilinear_height_sampler.sv -----
// Bilinear height sampler: grid store, coordinate mapping and blend pipeline.
//
// Channels: in_* carries one word per item (action 0 loads one grid cell,
// action 1 samples a world position); out_* returns one word per sample and
// none per load; cfg_* writes grid_side, land_radius and cells_per_unit and
// is always ready. All three use valid/ready and move a word when both are high.
// A sample word is registered in every stage and then in the output register before it shows on out_valid.
// Throughput: one word per cycle while no stage holds. The grid store is two copies of a 1-write,
// 2-read RAM so the four neighbour cells are fetched in the same cycle; loads write
// at the same stage where samples read, keeping load/sample order exact.
// Stalls: a stage holds only while it is full and the stage after it holds, so bubbles
// close up and in_ready stays high until all eight stages and the output
// register are full and out_ready is low.
// Reset: clears configuration to 0 and empties the pipeline. Grid contents
// are undefined until written; there is no clearing pass.
`include "bilinear_height_sampler_macros.svh"

module bilinear_height_sampler
  import bhs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  logic [CIDX_W-1:0]        in_cell_index,
  input  logic signed [HIN_W-1:0]  in_height_in,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [HOUT_W-1:0] out_height_out,
  output logic                     out_grid_unusable
);

  function automatic axis_t map_axis(input logic [2*POS_W-1:0] p, input logic nonpos,
                                     input logic [SIDE_W-1:0] lim);
    logic [POS_W-1:0] ip;
    axis_t a;
    ip = p[2*POS_W-1:POS_W];
    if (nonpos) begin
      a.base = '0;
      a.frac = '0;
    end else if (ip > POS_W'(lim)) begin
      a.base = lim;
      a.frac = FRAC_ONE;
    end else begin
      a.base = ip[SIDE_W-1:0];
      a.frac = {1'b0, p[POS_W-1 -: FRAC_W-1]};
    end
    return a;
  endfunction

  function automatic logic signed [Q_W-1:0] round_q(input logic signed [PM_W-1:0] v);
    logic signed [PM_W-1:0] t;
    t = v + PM_W'(ROUND_HALF);
    return Q_W'(t >>> FRAC_SHIFT);
  endfunction

  // Configuration
  logic [SIDE_W-1:0]   grid_side_r;
  logic [RADIUS_W-1:0] land_radius_r;
  logic [CPU_W-1:0]    cells_per_unit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r      <= '0;
      land_radius_r    <= '0;
      cells_per_unit_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_SIDE:      grid_side_r      <= cfg_data[SIDE_W-1:0];
        REG_LAND_RADIUS:    land_radius_r    <= cfg_data[RADIUS_W-1:0];
        REG_CELLS_PER_UNIT: cells_per_unit_r <= cfg_data[CPU_W-1:0];
        default: ;
      endcase
    end
  end

  logic [2*SIDE_W-1:0] side_sq;
  logic [SIDE_W-1:0]   lim;
  logic                unusable;

  assign side_sq  = grid_side_r * grid_side_r;
  assign lim      = grid_side_r - SIDE_W'(2);
  assign unusable = (grid_side_r < SIDE_W'(2)) || (land_radius_r == '0);

  // Stage valids and advance chain
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r, out_valid_r;
  logic s1_free, s2_free, s3_free, s4_free, s5_free, s6_free, s7_free, s8_free;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;
  assign s8_free  = !s8_v_r || out_free;
  assign s7_free  = !s7_v_r || s8_free;
  assign s6_free  = !s6_v_r || s7_free;
  assign s5_free  = !s5_v_r || s6_free;
  assign s4_free  = !s4_v_r || s5_free;
  assign s3_free  = !s3_v_r || s4_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;

  // Stage 1: capture word, offset positions by the radius
  logic                          s1_act_r;
  logic [CIDX_W-1:0]             s1_idx_r;
  logic [HEIGHT_BITS-1:0]        s1_hin_r;
  logic                          s1_wok_r;
  logic                          s1_unus_r;
  logic signed [SUM_W-1:0]       s1_sx_r, s1_sy_r;
  logic signed [SUM_W-1:0]       sx_nxt, sy_nxt;
  logic                          wok_nxt;

  assign sx_nxt  = SUM_W'(in_pos_x) + SUM_W'(land_radius_r);
  assign sy_nxt  = SUM_W'(in_pos_y) + SUM_W'(land_radius_r);
  assign wok_nxt = ((2*SIDE_W)'(in_cell_index) < side_sq) &&
                   (IDX_W'(in_cell_index) < IDX_W'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_act_r  <= in_action;
      s1_idx_r  <= in_cell_index;
      s1_hin_r  <= HEIGHT_BITS'(in_height_in);
      s1_wok_r  <= wok_nxt;
      s1_unus_r <= unusable;
      s1_sx_r   <= sx_nxt;
      s1_sy_r   <= sy_nxt;
    end
  end

  // Stage 2: scale by the reciprocal cell size
  logic                   s2_act_r;
  logic [CIDX_W-1:0]      s2_idx_r;
  logic [HEIGHT_BITS-1:0] s2_hin_r;
  logic                   s2_wok_r, s2_unus_r;
  logic [2*POS_W-1:0]     s2_px_r, s2_py_r;
  logic                   s2_npx_r, s2_npy_r;
  logic [2*POS_W-1:0]     px_nxt, py_nxt;
  logic [POS_W-1:0]       sx_mag, sy_mag;

  assign sx_mag = s1_sx_r[POS_W-1:0];
  assign sy_mag = s1_sy_r[POS_W-1:0];
  assign px_nxt = sx_mag * cells_per_unit_r;
  assign py_nxt = sy_mag * cells_per_unit_r;

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_act_r  <= s1_act_r;
      s2_idx_r  <= s1_idx_r;
      s2_hin_r  <= s1_hin_r;
      s2_wok_r  <= s1_wok_r;
      s2_unus_r <= s1_unus_r;
      s2_px_r   <= px_nxt;
      s2_py_r   <= py_nxt;
      s2_npx_r  <= s1_sx_r[SUM_W-1] || (s1_sx_r == '0);
      s2_npy_r  <= s1_sy_r[SUM_W-1] || (s1_sy_r == '0);
    end
  end

  // Stage 3: clamp base cell and fraction
  logic                   s3_act_r;
  logic [CIDX_W-1:0]      s3_idx_r;
  logic [HEIGHT_BITS-1:0] s3_hin_r;
  logic                   s3_wok_r, s3_unus_r;
  logic [SIDE_W-1:0]      s3_cx_r, s3_cy_r;
  logic [FRAC_W-1:0]      s3_fx_r, s3_fy_r;
  axis_t                  ax_nxt, ay_nxt;

  assign ax_nxt = map_axis(s2_px_r, s2_npx_r, lim);
  assign ay_nxt = map_axis(s2_py_r, s2_npy_r, lim);

  always_ff @(posedge clk) begin
    if (s3_free) begin
      s3_act_r  <= s2_act_r;
      s3_idx_r  <= s2_idx_r;
      s3_hin_r  <= s2_hin_r;
      s3_wok_r  <= s2_wok_r;
      s3_unus_r <= s2_unus_r;
      s3_cx_r   <= ax_nxt.base;
      s3_cy_r   <= ay_nxt.base;
      s3_fx_r   <= ax_nxt.frac;
      s3_fy_r   <= ay_nxt.frac;
    end
  end

  // Stage 4: cell index; store write and neighbour reads issue here
  logic                   s4_act_r;
  logic [CIDX_W-1:0]      s4_idx_r;
  logic [HEIGHT_BITS-1:0] s4_hin_r;
  logic                   s4_wok_r, s4_unus_r;
  logic [IDX_W-1:0]       s4_bidx_r;
  logic [FRAC_W-1:0]      s4_fx_r, s4_fy_r;
  logic [2*SIDE_W-1:0]    row_off;
  logic [IDX_W-1:0]       bidx_nxt;

  assign row_off  = s3_cy_r * grid_side_r;
  assign bidx_nxt = IDX_W'(row_off) + IDX_W'(s3_cx_r);

  always_ff @(posedge clk) begin
    if (s4_free) begin
      s4_act_r  <= s3_act_r;
      s4_idx_r  <= s3_idx_r;
      s4_hin_r  <= s3_hin_r;
      s4_wok_r  <= s3_wok_r;
      s4_unus_r <= s3_unus_r;
      s4_bidx_r <= bidx_nxt;
      s4_fx_r   <= s3_fx_r;
      s4_fy_r   <= s3_fy_r;
    end
  end

  logic [IDX_W-1:0]       i00, i10, i01, i11;
  logic [3:0]             oob_nxt;
  logic                   st_we, st_re;
  logic [ADDR_W-1:0]      st_waddr;
  logic [HEIGHT_BITS-1:0] rd00, rd10, rd01, rd11;

  assign i00      = s4_bidx_r;
  assign i10      = s4_bidx_r + IDX_W'(1);
  assign i01      = s4_bidx_r + IDX_W'(grid_side_r);
  assign i11      = i01 + IDX_W'(1);
  assign oob_nxt  = {i11 >= IDX_W'(STORE_DEPTH), i01 >= IDX_W'(STORE_DEPTH),
                     i10 >= IDX_W'(STORE_DEPTH), i00 >= IDX_W'(STORE_DEPTH)};
  assign st_re    = s5_free;
  assign st_we    = s5_free && s4_v_r && (s4_act_r == ACT_LOAD) && s4_wok_r;
  assign st_waddr = ADDR_W'(s4_idx_r);

  bhs_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(STORE_DEPTH)) u_ram_row0 (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (s4_hin_r),
    .re      (st_re),
    .raddr_a (ADDR_W'(i00)),
    .raddr_b (ADDR_W'(i10)),
    .rdata_a (rd00),
    .rdata_b (rd10)
  );

  bhs_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(STORE_DEPTH)) u_ram_row1 (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (s4_hin_r),
    .re      (st_re),
    .raddr_a (ADDR_W'(i01)),
    .raddr_b (ADDR_W'(i11)),
    .rdata_a (rd01),
    .rdata_b (rd11)
  );

  // Stage 5: neighbour cells; blend along x
  logic [3:0]                    s5_oob_r;
  logic [FRAC_W-1:0]             s5_fx_r, s5_fy_r;
  logic                          s5_unus_r;
  logic signed [HEIGHT_BITS-1:0] c00, c10, c01, c11;
  logic signed [DIFF_W-1:0]      dlo, dhi;
  logic signed [PM_W-1:0]        plo_nxt, phi_nxt;

  always_ff @(posedge clk) begin
    if (s5_free) begin
      s5_oob_r  <= oob_nxt;
      s5_fx_r   <= s4_fx_r;
      s5_fy_r   <= s4_fy_r;
      s5_unus_r <= s4_unus_r;
    end
  end

  assign c00     = s5_oob_r[0] ? '0 : $signed(rd00);
  assign c10     = s5_oob_r[1] ? '0 : $signed(rd10);
  assign c01     = s5_oob_r[2] ? '0 : $signed(rd01);
  assign c11     = s5_oob_r[3] ? '0 : $signed(rd11);
  assign dlo     = DIFF_W'(c10) - DIFF_W'(c00);
  assign dhi     = DIFF_W'(c11) - DIFF_W'(c01);
  assign plo_nxt = dlo * $signed({1'b0, s5_fx_r});
  assign phi_nxt = dhi * $signed({1'b0, s5_fx_r});

  // Stage 6: x products
  logic signed [PM_W-1:0]        s6_plo_r, s6_phi_r;
  logic signed [HEIGHT_BITS-1:0] s6_c00_r, s6_c01_r;
  logic [FRAC_W-1:0]             s6_fy_r;
  logic                          s6_unus_r;
  logic signed [HEIGHT_BITS-1:0] lo_nxt, hi_nxt;

  always_ff @(posedge clk) begin
    if (s6_free) begin
      s6_plo_r  <= plo_nxt;
      s6_phi_r  <= phi_nxt;
      s6_c00_r  <= c00;
      s6_c01_r  <= c01;
      s6_fy_r   <= s5_fy_r;
      s6_unus_r <= s5_unus_r;
    end
  end

  assign lo_nxt = HEIGHT_BITS'(Q_W'(s6_c00_r) + round_q(s6_plo_r));
  assign hi_nxt = HEIGHT_BITS'(Q_W'(s6_c01_r) + round_q(s6_phi_r));

  // Stage 7: row results; blend along y
  logic signed [HEIGHT_BITS-1:0] s7_lo_r, s7_hi_r;
  logic [FRAC_W-1:0]             s7_fy_r;
  logic                          s7_unus_r;
  logic signed [DIFF_W-1:0]      dy;
  logic signed [PM_W-1:0]        py_mul;

  always_ff @(posedge clk) begin
    if (s7_free) begin
      s7_lo_r   <= lo_nxt;
      s7_hi_r   <= hi_nxt;
      s7_fy_r   <= s6_fy_r;
      s7_unus_r <= s6_unus_r;
    end
  end

  assign dy     = DIFF_W'(s7_hi_r) - DIFF_W'(s7_lo_r);
  assign py_mul = dy * $signed({1'b0, s7_fy_r});

  // Stage 8: y product
  logic signed [PM_W-1:0]        s8_py_r;
  logic signed [HEIGHT_BITS-1:0] s8_lo_r;
  logic                          s8_unus_r;
  logic signed [HEIGHT_BITS-1:0] h_nxt;

  always_ff @(posedge clk) begin
    if (s8_free) begin
      s8_py_r   <= py_mul;
      s8_lo_r   <= s7_lo_r;
      s8_unus_r <= s7_unus_r;
    end
  end

  assign h_nxt = HEIGHT_BITS'(Q_W'(s8_lo_r) + round_q(s8_py_r));

  // Output register
  logic signed [HOUT_W-1:0] out_height_r;
  logic                     out_unus_r;

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_height_r <= s8_unus_r ? '0 : HOUT_W'(h_nxt);
      out_unus_r   <= s8_unus_r;
    end
  end

  // Valid bits; loads drop out once past the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      s7_v_r      <= 1'b0;
      s8_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free)  s1_v_r      <= in_valid;
      if (s2_free)  s2_v_r      <= s1_v_r;
      if (s3_free)  s3_v_r      <= s2_v_r;
      if (s4_free)  s4_v_r      <= s3_v_r;
      if (s5_free)  s5_v_r      <= s4_v_r && (s4_act_r == ACT_SAMPLE);
      if (s6_free)  s6_v_r      <= s5_v_r;
      if (s7_free)  s7_v_r      <= s6_v_r;
      if (s8_free)  s8_v_r      <= s7_v_r;
      if (out_free) out_valid_r <= s8_v_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_height_out    = out_height_r;
  assign out_grid_unusable = out_unus_r;

  `BHS_ASSERT_IMP(a_stall_from_output, !in_ready, out_valid_r && !out_ready,
                  "input stalled with output free")
  `BHS_ASSERT_IMP(a_unusable_zero, out_valid_r && out_unus_r, out_height_r == '0,
                  "unusable grid gave nonzero height")
  `BHS_ASSERT_IMP(a_clamp_range, s3_v_r && !s3_unus_r,
                  (s3_cx_r <= lim) && (s3_cy_r <= lim) &&
                  (s3_fx_r <= FRAC_ONE) && (s3_fy_r <= FRAC_ONE),
                  "base cell or fraction out of range")
  `BHS_ASSERT_IMP(a_sample_only_read, s5_v_r && $past(s5_free),
                  $past(s4_v_r && (s4_act_r == ACT_SAMPLE)),
                  "read stage holds a non-sample word")

endmodule
